// ----- rtl/core/pie_pkg.sv -----
// Shared types, constants and helper functions of the palette index expander.
package pie_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PALETTE_DEPTH = 256;

    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int OUT_DEPTH_DEFAULT   = 4;

    // Index sizes held in index_mode; the unused code behaves as 8-bit.
    localparam logic [1:0] MODE_1BIT = 2'd0;
    localparam logic [1:0] MODE_4BIT = 2'd1;
    localparam logic [1:0] MODE_8BIT = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_INDEX_MODE    = 3'd0;
    localparam logic [2:0] CFG_BYTES_PER_PIX = 3'd1;
    localparam logic [2:0] CFG_LINE_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_LINE_COUNT    = 3'd3;
    localparam logic [2:0] CFG_SRC_ALIGN     = 3'd4;
    localparam logic [2:0] CFG_FLIP_VERT     = 3'd5;

    localparam logic FUNC_PALETTE = 1'b0;
    localparam logic FUNC_IMAGE   = 1'b1;

    typedef struct packed {
        logic [1:0]  index_mode;
        logic [2:0]  bytes_per_pixel;
        logic [12:0] line_width;
        logic [12:0] line_count;
        logic [6:0]  src_alignment;
        logic        flip_vertical;
    } t_cfg;

    // One work entry handed from the front to the back.
    typedef struct packed {
        logic        is_pal;
        logic [7:0]  slot;
        logic [31:0] data;
        logic [12:0] col;
        logic [3:0]  cnt;
        logic [11:0] row;
        logic        last_row;
    } t_entry;

    typedef struct packed {
        logic [31:0] color;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_of_item;
        logic        last_of_image;
    } t_pixel;

    function automatic logic [12:0] f_clamp_width(input logic [12:0] v);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > 13'(MAX_WIDTH)) begin
            r = 13'(MAX_WIDTH);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [12:0] f_clamp_lines(input logic [12:0] v);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > 13'(MAX_HEIGHT)) begin
            r = 13'(MAX_HEIGHT);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Largest power of two not above the setting, limited to 1..64.
    function automatic logic [6:0] f_align(input logic [6:0] v);
        logic [6:0] r;
        r = 7'd1;
        if (v[6]) begin
            r = 7'd64;
        end else begin
            for (int i = 1; i < 6; i++) begin
                if (v[i]) r = 7'(1 << i);
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] f_color_mask(input logic [2:0] bpp);
        logic [31:0] r;
        case (bpp)
            3'd0, 3'd1: r = 32'h0000_00FF;
            3'd2:       r = 32'h0000_FFFF;
            3'd3:       r = 32'h00FF_FFFF;
            default:    r = 32'hFFFF_FFFF;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/pie_fifo.sv -----
// Small first-in first-out queue in flip-flops with a fill count.
module pie_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr, r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push_ok) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (pop_ok) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/pie_front.sv -----
// Front end: accepts items, tracks line position and builds work entries.
module pie_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pie_pkg::t_cfg   i_cfg,
    input  logic            i_accept,
    input  logic            i_func,
    input  logic [7:0]      i_palette_slot,
    input  logic [31:0]     i_palette_color,
    input  logic [7:0]      i_data_byte,
    output logic            o_q_push,
    output pie_pkg::t_entry o_q_data
);

    logic [12:0] r_col, n_col;
    logic [11:0] r_row, n_row;
    logic [12:0] r_lbc, n_lbc;

    logic [12:0] width, lines, useful, aligned, room, lbc_inc, row_inc, align_m1;
    logic [3:0]  per_byte, cnt;
    logic [11:0] row_out;
    logic        line_end, is_image;

    assign width    = pie_pkg::f_clamp_width(i_cfg.line_width);
    assign lines    = pie_pkg::f_clamp_lines(i_cfg.line_count);
    assign align_m1 = {6'b0, pie_pkg::f_align(i_cfg.src_alignment)} - 13'd1;
    assign is_image = (i_func == pie_pkg::FUNC_IMAGE);

    always_comb begin
        case (i_cfg.index_mode)
            pie_pkg::MODE_1BIT: begin
                per_byte = 4'd8;
                useful   = (width + 13'd7) >> 3;
            end
            pie_pkg::MODE_4BIT: begin
                per_byte = 4'd2;
                useful   = (width + 13'd1) >> 1;
            end
            default: begin
                per_byte = 4'd1;
                useful   = width;
            end
        endcase
    end

    assign aligned  = (useful + align_m1) & ~align_m1;
    assign room     = width - r_col;
    assign lbc_inc  = r_lbc + 13'd1;
    assign line_end = (lbc_inc >= aligned);
    assign row_inc  = {1'b0, r_row} + 13'd1;

    always_comb begin
        if (r_col >= width) begin
            cnt = 4'd0;
        end else if (room < {9'b0, per_byte}) begin
            cnt = room[3:0];
        end else begin
            cnt = per_byte;
        end
    end

    always_comb begin
        if (!i_cfg.flip_vertical) begin
            row_out = r_row;
        end else if ({1'b0, r_row} < lines) begin
            row_out = 12'(lines - 13'd1 - {1'b0, r_row});
        end else begin
            row_out = '0;
        end
    end

    // Image bytes that yield no pixel only move the counters.
    assign o_q_push          = i_accept && (!is_image || (cnt != 4'd0));
    assign o_q_data.is_pal   = !is_image;
    assign o_q_data.slot     = i_palette_slot;
    assign o_q_data.data     = is_image ? {24'b0, i_data_byte} : i_palette_color;
    assign o_q_data.col      = r_col;
    assign o_q_data.cnt      = cnt;
    assign o_q_data.row      = row_out;
    assign o_q_data.last_row = ({1'b0, r_row} == lines - 13'd1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_lbc = r_lbc;
        if (i_accept && is_image) begin
            if (line_end) begin
                n_col = '0;
                n_lbc = '0;
                n_row = (row_inc >= lines) ? '0 : row_inc[11:0];
            end else begin
                n_col = r_col + {9'b0, cnt};
                n_lbc = lbc_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_lbc <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_lbc <= n_lbc;
        end
    end

endmodule

// ----- rtl/core/pie_back.sv -----
// Back end: owns the palette memory and expands entries into pixels.
module pie_back #(
    parameter int OUT_DEPTH = pie_pkg::OUT_DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pie_pkg::t_cfg                    i_cfg,
    input  pie_pkg::t_entry                  i_head,
    input  logic                             i_q_empty,
    output logic                             o_q_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]   i_out_count,
    output logic                             o_out_push,
    output pie_pkg::t_pixel                  o_out_data
);

    logic [31:0] r_palette [pie_pkg::PALETTE_DEPTH];
    logic [31:0] r_rdata;

    logic [2:0]  r_k, n_k;
    logic        r_s1_valid;
    logic [11:0] r_s1_column, r_s1_row;
    logic        r_s1_last_item, r_s1_last_image;

    logic        credit, pal_we, pix_re, last_pix;
    logic [7:0]  idx, pix_byte;
    logic [12:0] col, width;

    // Issue only when the result queue has room for the read in flight.
    assign credit   = (int'(i_out_count) + int'(r_s1_valid)) < OUT_DEPTH;
    assign pal_we   = !i_q_empty && i_head.is_pal;
    assign pix_re   = !i_q_empty && !i_head.is_pal && credit;
    assign last_pix = ({1'b0, r_k} == i_head.cnt - 4'd1);
    assign o_q_pop  = pal_we || (pix_re && last_pix);
    assign pix_byte = i_head.data[7:0];
    assign col      = i_head.col + {10'b0, r_k};
    assign width    = pie_pkg::f_clamp_width(i_cfg.line_width);

    always_comb begin
        case (i_cfg.index_mode)
            pie_pkg::MODE_1BIT: idx = {7'b0, pix_byte[3'd7 - r_k]};
            pie_pkg::MODE_4BIT: idx = r_k[0] ? {4'b0, pix_byte[3:0]} : {4'b0, pix_byte[7:4]};
            default:            idx = pix_byte;
        endcase
    end

    always_comb begin
        n_k = r_k;
        if (pix_re) begin
            n_k = last_pix ? 3'd0 : r_k + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_palette[i_head.slot] <= i_head.data;
        end
        if (pix_re) begin
            r_rdata <= r_palette[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k        <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_k        <= n_k;
            r_s1_valid <= pix_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_re) begin
            r_s1_column     <= col[11:0];
            r_s1_row        <= i_head.row;
            r_s1_last_item  <= last_pix;
            r_s1_last_image <= i_head.last_row && (col == width - 13'd1);
        end
    end

    assign o_out_push               = r_s1_valid;
    assign o_out_data.color         = r_rdata & pie_pkg::f_color_mask(i_cfg.bytes_per_pixel);
    assign o_out_data.column        = r_s1_column;
    assign o_out_data.row           = r_s1_row;
    assign o_out_data.last_of_item  = r_s1_last_item;
    assign o_out_data.last_of_image = r_s1_last_image;

endmodule

// ----- rtl/core/palette_index_expander_unit.sv -----
// Top level of the palette index expander: configuration registers and the datapath.
//
// Usage. Items enter through a queue-style port: an item transfers on a rising edge
// with push high and full low. An item with func low loads one palette entry; an item
// with func high carries one source byte of packed 1-, 4- or 8-bit indices, most
// significant first. Results leave through a second queue-style port: the oldest
// pixel sits on the o_pixel_* ports while empty is low and transfers on an edge with
// pop high. Each pixel carries its palette color, column and output row, and flags
// for the last pixel of its byte and of the image.
// Configuration registers are written through i_cfg_we, i_cfg_index and i_cfg_data
// while the block is idle; writes to unused indexes are ignored.
// The first pixel of a byte passes the work queue, the registered palette read and
// the result queue before it shows on the result port. Throughput: one pixel per cycle
// while the result queue has room, set by the single read port of the palette memory in
// the back end; a byte yields up to eight pixels in 1-bit mode, up to two in 4-bit mode and one in 8-bit mode.
// The front end tracks line position and hands entries through a short work queue,
// so input keeps flowing while the back end expands an earlier byte.
// Reset clears the counters and both queues and loads the register defaults; the
// palette contents stay undefined until written. When pop stays low, the result
// queue fills, the back end pauses, the work queue fills and full rises.
module palette_index_expander_unit #(
    parameter int QUEUE_DEPTH = pie_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int OUT_DEPTH   = pie_pkg::OUT_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [7:0]  i_palette_slot,
    input  logic [31:0] i_palette_color,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_pixel_color,
    output logic [11:0] o_pixel_column,
    output logic [11:0] o_pixel_row,
    output logic        o_last_of_item,
    output logic        o_last_of_image
);

    pie_pkg::t_cfg   r_cfg;
    pie_pkg::t_entry q_in, q_head;
    pie_pkg::t_pixel out_in, out_head;

    logic                           q_push, q_pop, q_empty, out_push;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

    // Register writes take effect at the edge where the write enable is seen.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.index_mode      <= pie_pkg::MODE_8BIT;
            r_cfg.bytes_per_pixel <= 3'd3;
            r_cfg.line_width      <= 13'd1;
            r_cfg.line_count      <= 13'd1;
            r_cfg.src_alignment   <= 7'd4;
            r_cfg.flip_vertical   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pie_pkg::CFG_INDEX_MODE:    r_cfg.index_mode      <= i_cfg_data[1:0];
                pie_pkg::CFG_BYTES_PER_PIX: r_cfg.bytes_per_pixel <= i_cfg_data[2:0];
                pie_pkg::CFG_LINE_WIDTH:    r_cfg.line_width      <= i_cfg_data;
                pie_pkg::CFG_LINE_COUNT:    r_cfg.line_count      <= i_cfg_data;
                pie_pkg::CFG_SRC_ALIGN:     r_cfg.src_alignment   <= i_cfg_data[6:0];
                pie_pkg::CFG_FLIP_VERT:     r_cfg.flip_vertical   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The front end sees every transfer, including bytes that yield no pixel.
    pie_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_accept        (push && !full),
        .i_func          (i_func),
        .i_palette_slot  (i_palette_slot),
        .i_palette_color (i_palette_color),
        .i_data_byte     (i_data_byte),
        .o_q_push        (q_push),
        .o_q_data        (q_in)
    );

    // Work queue between the two halves; its full flag is the input back-pressure.
    pie_fifo #(
        .WIDTH ($bits(pie_pkg::t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_empty (q_empty),
        .o_count ()
    );

    pie_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (q_head),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (out_in)
    );

    // Result queue; the back end never pushes into it without a free slot.
    pie_fifo #(
        .WIDTH ($bits(pie_pkg::t_pixel)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .o_full  (),
        .i_pop   (pop),
        .o_data  (out_head),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_pixel_color   = out_head.color;
    assign o_pixel_column  = out_head.column;
    assign o_pixel_row     = out_head.row;
    assign o_last_of_item  = out_head.last_of_item;
    assign o_last_of_image = out_head.last_of_image;

endmodule

// ----- rtl/core/pie_checker.sv -----
// Port-level checks of the palette index expander and their binding to the top level.
module pie_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_pixel_color,
    input logic [11:0] o_pixel_column,
    input logic        o_last_of_item,
    input logic        o_last_of_image
);

    // Reset leaves the result queue empty and the work queue not full.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // A waiting pixel stays in place until it transfers.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pixel_color) && $stable(o_pixel_column)))
        else $error("result changed while stalled");

    // The final pixel of an image always closes its source byte.
    a_image_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last_of_image) |-> o_last_of_item)
        else $error("last_of_image without last_of_item");

    // Pixels of one byte come out in consecutive columns.
    a_columns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_of_item) |=>
        (empty || o_pixel_column == 12'($past(o_pixel_column) + 12'd1)))
        else $error("column gap inside one source byte");

endmodule

bind palette_index_expander_unit pie_checker u_pie_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_pixel_color   (o_pixel_color),
    .o_pixel_column  (o_pixel_column),
    .o_last_of_item  (o_last_of_item),
    .o_last_of_image (o_last_of_image)
);
